>>> sv/hfm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfm_pkg: shared types and constants of the hash frequency mode block
// Table geometry, field widths, hash multiplier, register map and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package hfm_pkg;

    // table geometry
    localparam int SLOTS      = 1024;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int SIZE_W     = SLOT_W + 1;
    localparam int COUNT_BITS = 16;
    localparam int KEY_W      = 32;
    localparam int STEP_W     = $clog2(KEY_W);

    // hash multiplier
    localparam logic [KEY_W-1:0] HASH_MUL = KEY_W'(16161);

    // register map (byte addresses)
    localparam int            ADDR_W          = 2;
    localparam logic [ADDR_W-1:0] REG_TABLE_SIZE = 2'd0;
    localparam logic [SIZE_W-1:0] SIZE_RESET     = SIZE_W'(SLOTS);

    // one table entry
    typedef struct packed {
        logic [KEY_W-1:0]      key;
        logic [COUNT_BITS-1:0] count;
    } t_slot;

    // controller to datapath commands
    typedef struct packed {
        logic load_item;
        logic hash_start;
        logic probe_rd;
        logic probe_upd;
        logic scan_init;
        logic scan_rd;
        logic result_load;
        logic clr_wr;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic key_zero;
        logic last;
        logic hash_done;
        logic probe_found;
        logic probe_last;
        logic scan_end;
        logic clr_end;
    } t_dp_stat;

endpackage

>>> sv/hfm_mod_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfm_mod_unit: home slot calculation
// Multiplies the key by the hash constant, then reduces the product modulo
// the table size with a restoring remainder, one bit per cycle.
// ----------------------------------------------------------------------------
module hfm_mod_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [hfm_pkg::KEY_W-1:0]   i_key,
    input  logic [hfm_pkg::SIZE_W-1:0]  i_size,
    output logic                        o_done,
    output logic [hfm_pkg::SLOT_W-1:0]  o_rem
);

    logic [hfm_pkg::KEY_W-1:0]  w_prod;
    logic [hfm_pkg::SIZE_W-1:0] w_rem_sh;
    logic [hfm_pkg::SIZE_W-1:0] w_rem_nx;

    logic [hfm_pkg::KEY_W-1:0]  r_div;
    logic [hfm_pkg::SLOT_W-1:0] r_rem;
    logic [hfm_pkg::STEP_W-1:0] r_cnt;
    logic                       r_busy;
    logic                       r_done;

    // product wraps at 32 bits
    assign w_prod = i_key * hfm_pkg::HASH_MUL;

    // one restoring step: shift in next dividend bit, subtract if it fits
    assign w_rem_sh = {r_rem, r_div[hfm_pkg::KEY_W-1]};
    assign w_rem_nx = (w_rem_sh >= i_size) ? (w_rem_sh - i_size) : w_rem_sh;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == hfm_pkg::STEP_W'(hfm_pkg::KEY_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // dividend and remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= w_prod;
            r_rem <= '0;
        end else if (r_busy) begin
            r_div <= {r_div[hfm_pkg::KEY_W-2:0], 1'b0};
            r_rem <= w_rem_nx[hfm_pkg::SLOT_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

>>> sv/hfm_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfm_datapath: slot table and working registers
// Holds the slot memory, the probe and scan pointers, the running best
// entry and the overflow flag. Acts on commands from the controller.
// ----------------------------------------------------------------------------
module hfm_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  hfm_pkg::t_dp_cmd                i_cmd,
    input  logic [hfm_pkg::KEY_W-1:0]       i_key,
    input  logic                            i_last,
    input  logic [hfm_pkg::SIZE_W-1:0]      i_size,
    output hfm_pkg::t_dp_stat               o_stat,
    output logic [hfm_pkg::KEY_W-1:0]       o_best_key,
    output logic [hfm_pkg::COUNT_BITS-1:0]  o_best_count,
    output logic                            o_ovf
);

    // slot memory
    hfm_pkg::t_slot mem [hfm_pkg::SLOTS];

    logic [hfm_pkg::KEY_W-1:0]      r_key;
    logic                           r_last;
    logic [hfm_pkg::SLOT_W-1:0]     r_pos;
    logic [hfm_pkg::SIZE_W-1:0]     r_probes;
    logic [hfm_pkg::SLOT_W-1:0]     r_scan;
    logic                           r_scan_v;
    logic [hfm_pkg::SLOT_W-1:0]     r_clr;
    hfm_pkg::t_slot                 r_rd;
    logic [hfm_pkg::KEY_W-1:0]      r_best_key;
    logic [hfm_pkg::COUNT_BITS-1:0] r_best_count;
    logic                           r_ovf;

    logic                           w_hash_done;
    logic [hfm_pkg::SLOT_W-1:0]     w_home;
    logic [hfm_pkg::SIZE_W-1:0]     w_pos_inc;
    logic [hfm_pkg::SLOT_W-1:0]     w_pos_nx;
    logic                           w_empty;
    logic                           w_match;
    logic                           w_probe_last;
    logic                           w_wr_en;
    logic [hfm_pkg::SLOT_W-1:0]     w_wr_addr;
    hfm_pkg::t_slot                 w_wr_data;
    logic [hfm_pkg::SLOT_W-1:0]     w_rd_addr;

    // home slot
    hfm_mod_unit u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.hash_start),
        .i_key   (r_key),
        .i_size  (i_size),
        .o_done  (w_hash_done),
        .o_rem   (w_home)
    );

    // probe decisions
    assign w_empty      = (r_rd.key == '0);
    assign w_match      = (r_rd.key == r_key);
    assign w_probe_last = ((r_probes + 1'b1) == i_size);
    assign w_pos_inc    = {1'b0, r_pos} + 1'b1;
    assign w_pos_nx     = (w_pos_inc >= i_size) ? '0 : w_pos_inc[hfm_pkg::SLOT_W-1:0];

    // write port: insert or update on a probe, zero on the clearing pass
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_pos;
        w_wr_data = '0;
        if (i_cmd.clr_wr) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_clr;
        end else if (i_cmd.probe_upd) begin
            if (w_empty) begin
                w_wr_en         = 1'b1;
                w_wr_data.key   = r_key;
                w_wr_data.count = hfm_pkg::COUNT_BITS'(1);
            end else if (w_match) begin
                w_wr_en         = 1'b1;
                w_wr_data.key   = r_key;
                w_wr_data.count = (r_rd.count == '1) ? r_rd.count : r_rd.count + 1'b1;
            end
        end
    end

    assign w_rd_addr = i_cmd.scan_rd ? r_scan : r_pos;

    // memory access, registered read
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[w_wr_addr] <= w_wr_data;
        end
        if (i_cmd.probe_rd || i_cmd.scan_rd) begin
            r_rd <= mem[w_rd_addr];
        end
    end

    // item, probe and scan pointers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_key  <= i_key;
            r_last <= i_last;
        end
        if (w_hash_done) begin
            r_pos    <= w_home;
            r_probes <= '0;
        end else if (i_cmd.probe_upd) begin
            r_pos    <= w_pos_nx;
            r_probes <= r_probes + 1'b1;
        end
        if (i_cmd.scan_init) begin
            r_scan <= '0;
        end else if (i_cmd.scan_rd) begin
            r_scan <= r_scan + 1'b1;
        end
    end

    // running best during the scan, lowest slot kept on a tie
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_best_key   <= '0;
            r_best_count <= '0;
        end else if (r_scan_v && (r_rd.key != '0) && (r_rd.count > r_best_count)) begin
            r_best_key   <= r_rd.key;
            r_best_count <= r_rd.count;
        end
    end

    // control state: overflow flag, clear pointer, scan read valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovf    <= 1'b0;
            r_clr    <= '0;
            r_scan_v <= 1'b0;
        end else begin
            r_scan_v <= i_cmd.scan_rd;
            if (i_cmd.result_load) begin
                r_ovf <= 1'b0;
            end else if (i_cmd.probe_upd && !w_empty && !w_match && w_probe_last) begin
                r_ovf <= 1'b1;
            end
            if (i_cmd.clr_wr) begin
                r_clr <= (r_clr == hfm_pkg::SLOT_W'(hfm_pkg::SLOTS - 1)) ? '0 : r_clr + 1'b1;
            end
        end
    end

    // status
    assign o_stat.key_zero    = (r_key == '0);
    assign o_stat.last        = r_last;
    assign o_stat.hash_done   = w_hash_done;
    assign o_stat.probe_found = w_empty || w_match;
    assign o_stat.probe_last  = w_probe_last;
    assign o_stat.scan_end    = (({1'b0, r_scan} + 1'b1) == i_size);
    assign o_stat.clr_end     = (r_clr == hfm_pkg::SLOT_W'(hfm_pkg::SLOTS - 1));

    assign o_best_key   = r_best_key;
    assign o_best_count = r_best_count;
    assign o_ovf        = r_ovf;

endmodule

>>> sv/hfm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfm_ctrl: sequencer of the hash frequency mode block
// Steps each non-zero key through hashing and probing, and on the last key
// of a batch, zero or not, through the scan, result hand-off and table clear.
// ----------------------------------------------------------------------------
module hfm_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_out_free,
    input  hfm_pkg::t_dp_stat  i_stat,
    output logic               o_in_ready,
    output hfm_pkg::t_dp_cmd   o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_HASH,
        ST_PROBE_RD,
        ST_PROBE_CMP,
        ST_SCAN_INIT,
        ST_SCAN,
        ST_SCAN_WAIT,
        ST_RESULT,
        ST_CLEAR
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_stat.key_zero) begin
                    n_state = i_stat.last ? ST_SCAN_INIT : ST_IDLE;
                end else begin
                    o_cmd.hash_start = 1'b1;
                    n_state          = ST_HASH;
                end
            end
            ST_HASH: begin
                if (i_stat.hash_done) begin
                    n_state = ST_PROBE_RD;
                end
            end
            ST_PROBE_RD: begin
                o_cmd.probe_rd = 1'b1;
                n_state        = ST_PROBE_CMP;
            end
            ST_PROBE_CMP: begin
                o_cmd.probe_upd = 1'b1;
                if (i_stat.probe_found || i_stat.probe_last) begin
                    n_state = i_stat.last ? ST_SCAN_INIT : ST_IDLE;
                end else begin
                    n_state = ST_PROBE_RD;
                end
            end
            ST_SCAN_INIT: begin
                o_cmd.scan_init = 1'b1;
                n_state         = ST_SCAN;
            end
            ST_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_stat.scan_end) begin
                    n_state = ST_SCAN_WAIT;
                end
            end
            ST_SCAN_WAIT: begin
                n_state = ST_RESULT;
            end
            ST_RESULT: begin
                if (i_out_free) begin
                    o_cmd.result_load = 1'b1;
                    n_state           = ST_CLEAR;
                end
            end
            ST_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.clr_end) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // state register; reset starts with a clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

endmodule

>>> sv/hash_frequency_mode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hash_frequency_mode: key frequency count with mode output
// One key at a time: each key goes through the bit-serial modulo and the
//   single-port probe loop before the next is taken; a zero key skips both.
//   The last key of a batch adds a scan of the table to its result.
// Reset: synchronous; all 1024 slots of the table are swept clear after reset
//   and after every result, and no key is taken during the sweep.
// ----------------------------------------------------------------------------
module hash_frequency_mode (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // key input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [31:0]                    s_tdata,   // [31:0] key
    input  logic                           s_tlast,   // last key of batch
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [47:0]                    m_tdata,   // [31:0] mode_key, [47:32] mode_count
    output logic                           m_tuser,   // [0] overflow
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [hfm_pkg::ADDR_W-1:0]     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    logic [hfm_pkg::SIZE_W-1:0]     r_table_size;
    logic [hfm_pkg::SIZE_W-1:0]     w_size;
    logic                           r_out_valid;
    logic [hfm_pkg::KEY_W-1:0]      r_out_key;
    logic [hfm_pkg::COUNT_BITS-1:0] r_out_count;
    logic                           r_out_ovf;
    logic                           w_out_free;
    logic                           w_in_ready;
    hfm_pkg::t_dp_cmd               w_cmd;
    hfm_pkg::t_dp_stat              w_stat;
    logic [hfm_pkg::KEY_W-1:0]      w_best_key;
    logic [hfm_pkg::COUNT_BITS-1:0] w_best_count;
    logic                           w_ovf;

    // configuration register
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= hfm_pkg::SIZE_RESET;
        end else if (psel && penable && pwrite && pready &&
                     (paddr == hfm_pkg::REG_TABLE_SIZE)) begin
            r_table_size <= pwdata[hfm_pkg::SIZE_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == hfm_pkg::REG_TABLE_SIZE) begin
            prdata = 32'(r_table_size);
        end
    end

    // effective size: zero acts as one, above the table acts as the table
    always_comb begin
        if (r_table_size == '0) begin
            w_size = hfm_pkg::SIZE_W'(1);
        end else if (r_table_size > hfm_pkg::SIZE_RESET) begin
            w_size = hfm_pkg::SIZE_RESET;
        end else begin
            w_size = r_table_size;
        end
    end

    hfm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_tvalid),
        .i_out_free (w_out_free),
        .i_stat     (w_stat),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    hfm_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_key        (s_tdata),
        .i_last       (s_tlast),
        .i_size       (w_size),
        .o_stat       (w_stat),
        .o_best_key   (w_best_key),
        .o_best_count (w_best_count),
        .o_ovf        (w_ovf)
    );

    assign s_tready = w_in_ready;

    // output register
    assign w_out_free = !r_out_valid || m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_cmd.result_load) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.result_load) begin
            r_out_key   <= w_best_key;
            r_out_count <= w_best_count;
            r_out_ovf   <= w_ovf;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {r_out_count, r_out_key};
    assign m_tuser  = r_out_ovf;

endmodule

>>> test/tb_hash_frequency_mode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hash_frequency_mode: self-checking bench for the key frequency mode block
// Streams batches of keys at many table sizes, keeps its own open-addressed
// count table to predict mode key, mode count and overflow of each batch, and
// compares every result transaction in order. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_hash_frequency_mode;

    localparam int unsigned LIMIT      = 3_000_000;
    localparam int unsigned SETTLE     = 2200;   // longest key walk or clear sweep
    localparam int unsigned TOTAL_KEYS = 700;
    localparam int unsigned CALM_KEYS  = 100;
    localparam logic [hfm_pkg::COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [hfm_pkg::KEY_W-1:0] key;
        logic                      last;
    } t_key_item;

    typedef struct packed {
        logic [hfm_pkg::KEY_W-1:0]      key;
        logic [hfm_pkg::COUNT_BITS-1:0] count;
        logic                           ovf;
    } t_mode_result;

    logic                       i_clk    = 1'b0;
    logic                       i_rst_n  = 1'b0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    logic [31:0]                s_tdata  = '0;   // [31:0] key
    logic                       s_tlast  = 1'b0; // last key of batch
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic [47:0]                m_tdata;         // [31:0] mode_key, [47:32] mode_count
    logic                       m_tuser;         // [0] overflow
    logic                       psel     = 1'b0;
    logic                       penable  = 1'b0;
    logic                       pwrite   = 1'b0;
    logic [hfm_pkg::ADDR_W-1:0] paddr    = '0;
    logic [31:0]                pwdata   = '0;
    logic [31:0]                prdata;
    logic                       pready;

    // own copy of the count table and the size register
    logic [hfm_pkg::KEY_W-1:0]      tbl_key [hfm_pkg::SLOTS];
    logic [hfm_pkg::COUNT_BITS-1:0] tbl_cnt [hfm_pkg::SLOTS];
    logic                           tbl_ovf;
    logic [hfm_pkg::SIZE_W-1:0]     size_reg;

    t_key_item    key_q [$];
    t_mode_result expected_modes [$];

    int unsigned keys_queued  = 0;
    int unsigned keys_taken   = 0;
    int unsigned keys_counted = 0;
    int unsigned batches      = 0;
    int unsigned results_seen = 0;
    int unsigned sizes_set    = 0;
    int unsigned mismatches   = 0;
    int unsigned cycles       = 0;
    int unsigned gap_odds     = 0;
    int unsigned stall_odds   = 0;
    int unsigned gap_left     = 0;
    int unsigned stall_left   = 0;

    int unsigned size_menu [13] = '{0, 1, 2, 3, 4, 5, 8, 16, 37, 100, 512, 1024, 2047};

    hash_frequency_mode u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] %s: expected %h, got %h", $time, what, want, got);
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) note_mismatch(what, want, got);
    endtask

    // effective number of slots
    function automatic int unsigned live_size();
        if (size_reg == 0) return 1;
        if (size_reg > hfm_pkg::SLOTS) return hfm_pkg::SLOTS;
        return size_reg;
    endfunction

    // count one key; on the last key scan for the mode and clear the table
    task automatic tally_key(input logic [hfm_pkg::KEY_W-1:0] k, input logic lst);
        int unsigned                    sz;
        int unsigned                    pos;
        int unsigned                    n;
        logic [hfm_pkg::KEY_W-1:0]      prod;
        logic [hfm_pkg::KEY_W-1:0]      best_key;
        logic [hfm_pkg::COUNT_BITS-1:0] best_cnt;
        bit                             placed;
        t_mode_result                   r;
        sz = live_size();
        if (k != 0) begin
            prod   = hfm_pkg::HASH_MUL * k;
            pos    = prod % sz;
            placed = 1'b0;
            for (n = 0; n < sz && !placed; n++) begin
                if (tbl_key[pos] == 0) begin
                    tbl_key[pos] = k;
                    tbl_cnt[pos] = hfm_pkg::COUNT_BITS'(1);
                    placed = 1'b1;
                end else if (tbl_key[pos] == k) begin
                    if (tbl_cnt[pos] != COUNT_MAX) tbl_cnt[pos] = tbl_cnt[pos] + 1'b1;
                    placed = 1'b1;
                end else begin
                    pos = (pos + 1 == sz) ? 0 : pos + 1;
                end
            end
            if (!placed) tbl_ovf = 1'b1;
        end
        if (lst) begin
            best_key = '0;
            best_cnt = '0;
            for (n = 0; n < sz; n++) begin
                if (tbl_key[n] != 0 && tbl_cnt[n] > best_cnt) begin
                    best_cnt = tbl_cnt[n];
                    best_key = tbl_key[n];
                end
            end
            r.key   = best_key;
            r.count = best_cnt;
            r.ovf   = tbl_ovf;
            expected_modes.push_back(r);
            for (n = 0; n < hfm_pkg::SLOTS; n++) begin
                tbl_key[n] = '0;
                tbl_cnt[n] = '0;
            end
            tbl_ovf = 1'b0;
            batches++;
        end
    endtask

    // key stream driver
    always @(posedge i_clk) begin
        t_key_item it;
        if (s_tvalid && s_tready) begin
            tally_key(s_tdata, s_tlast);
            keys_taken++;
        end
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
                gap_left <= $urandom_range(0, 18);
                s_tvalid <= 1'b0;
            end else if (key_q.size() > 0) begin
                it = key_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= it.key;
                s_tlast  <= it.last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge i_clk) begin
        t_mode_result want;
        if (m_tvalid && m_tready) begin
            results_seen++;
            if (expected_modes.size() == 0) begin
                note_mismatch("result with nothing expected", '0, m_tdata[31:0]);
            end else begin
                want = expected_modes.pop_front();
                check_field("mode_key", want.key, m_tdata[31:0]);
                check_field("mode_count", 32'(want.count), 32'(m_tdata[47:32]));
                check_field("overflow", 32'(want.ovf), 32'(m_tuser));
            end
        end
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
            stall_left <= $urandom_range(0, 18);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic add_key(input logic [hfm_pkg::KEY_W-1:0] k, input logic lst);
        t_key_item it;
        it.key  = k;
        it.last = lst;
        key_q.push_back(it);
        keys_queued++;
        if (k != 0 || lst) keys_counted++;
    endtask

    // wait until every key is taken and every result is back, then let it settle
    task automatic drain();
        while (keys_taken != keys_queued || expected_modes.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // register write followed by a read back
    task automatic write_size(input logic [hfm_pkg::SIZE_W-1:0] v);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= hfm_pkg::REG_TABLE_SIZE;
        pwdata  <= 32'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        size_reg = v;
        sizes_set++;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        check_field("table_size read back", 32'(v), prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // one batch drawn from a small key pool sized to the table
    task automatic make_batch();
        logic [hfm_pkg::KEY_W-1:0] pool [$];
        logic [hfm_pkg::KEY_W-1:0] k;
        logic [hfm_pkg::KEY_W-1:0] base;
        int unsigned               sz;
        int unsigned               npool;
        int unsigned               len;
        int unsigned               j;
        sz    = live_size();
        npool = $urandom_range(1, (sz < 10) ? sz + 2 : 12);
        base  = $urandom_range(1, 5000);
        for (j = 0; j < npool; j++) begin
            case ($urandom_range(0, 3))
                0: k = $urandom;
                1: k = base + j * sz;          // shares one home slot
                2: k = $urandom_range(1, 40);
                default: k = -($urandom_range(1, 40));
            endcase
            pool.push_back(k);
        end
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        for (j = 0; j < len; j++) begin
            k = ($urandom_range(0, 11) == 0) ? '0 : pool[$urandom_range(0, pool.size() - 1)];
            add_key(k, j == len - 1);
        end
    endtask

    // stimulus
    initial begin
        int unsigned n;
        int unsigned waited;
        for (n = 0; n < hfm_pkg::SLOTS; n++) begin
            tbl_key[n] = '0;
            tbl_cnt[n] = '0;
        end
        tbl_ovf  = 1'b0;
        size_reg = hfm_pkg::SIZE_RESET;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // key extremes at the reset size
        add_key(32'h7FFF_FFFF, 1'b0);
        add_key(32'h8000_0000, 1'b0);
        add_key(32'h7FFF_FFFF, 1'b0);
        add_key(32'hFFFF_FFFF, 1'b0);
        add_key(32'h0000_0001, 1'b0);
        add_key(32'h7FFF_FFFF, 1'b1);
        // a lone zero key still closes its batch
        add_key(32'h0, 1'b1);
        // equal counts, lowest slot wins
        add_key(32'd5, 1'b0);
        add_key(32'd9, 1'b0);
        add_key(32'd9, 1'b0);
        add_key(32'd5, 1'b1);
        drain();
        // full table drops a key and flags overflow
        write_size(11'd2);
        add_key(32'd10, 1'b0);
        add_key(32'd20, 1'b0);
        add_key(32'd30, 1'b0);
        add_key(32'd20, 1'b0);
        add_key(32'd10, 1'b1);
        drain();
        // size zero behaves as one slot
        write_size(11'd0);
        add_key(32'd3, 1'b0);
        add_key(32'd4, 1'b0);
        add_key(32'd3, 1'b1);
        drain();
        // oversize register clamps, then the size shrinks inside a batch
        write_size(11'h7FF);
        add_key(32'd11, 1'b0);
        add_key(32'd12, 1'b0);
        add_key(32'd13, 1'b0);
        add_key(32'd14, 1'b0);
        drain();
        write_size(11'd3);
        add_key(32'd11, 1'b0);
        add_key(32'h0, 1'b1);

        // random phases, each at its own size and idling mix
        while (keys_counted < TOTAL_KEYS) begin
            drain();
            write_size(hfm_pkg::SIZE_W'(size_menu[$urandom_range(0, 12)]));
            if (keys_counted >= TOTAL_KEYS - CALM_KEYS) begin
                gap_odds   = 0;
                stall_odds = 0;
            end else begin
                gap_odds   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 8);
                stall_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 8);
            end
            repeat ($urandom_range(2, 6)) begin
                make_batch();
                // the closing stretch of the run goes without idling
                if (keys_counted >= TOTAL_KEYS - CALM_KEYS) begin
                    gap_odds   = 0;
                    stall_odds = 0;
                end
            end
        end

        // wind down
        gap_odds   = 0;
        stall_odds = 0;
        while (keys_taken != keys_queued) @(posedge i_clk);
        waited = 0;
        while (expected_modes.size() != 0 && waited < 20 * SETTLE) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE) @(posedge i_clk);
        if (expected_modes.size() != 0)
            note_mismatch("results never delivered", '0, expected_modes.size());

        $display("covered %0d keys (%0d counted) in %0d batches over %0d size settings",
                 keys_queued, keys_counted, batches, sizes_set);
        $display("%0d results compared, %0d mismatches", results_seen, mismatches);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

>>> hash_frequency_mode.f
sv/hfm_pkg.sv
sv/hfm_mod_unit.sv
sv/hfm_datapath.sv
sv/hfm_ctrl.sv
sv/hash_frequency_mode.sv
test/tb_hash_frequency_mode.sv
